// ===== rtl/gabb_pkg.sv =====
// ----------------------------------------------------------------------------
// gabb_pkg
// Types, register map and limits shared by the glyph alpha blend blitter.
// ----------------------------------------------------------------------------
package gabb_pkg;

  localparam int MAX_GLYPH_DIM = 255;
  localparam int MAX_BUF_DIM   = 4096;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FG_COLOR    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BUF_WIDTH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BUF_HEIGHT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_PITCH   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH = 3'd6;

  typedef struct packed {
    logic [7:0]  coverage;
    logic [23:0] background_pixel;
    logic        first_of_glyph;
  } item_t;

  typedef struct packed {
    logic        write_enable;
    logic [24:0] word_address;
    logic [23:0] blended_pixel;
  } result_t;

  typedef struct packed {
    logic [23:0]        fg_color;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [12:0]        buf_width;
    logic [12:0]        buf_height;
    logic [13:0]        row_pitch;
    logic [7:0]         glyph_width;
  } cfg_t;

endpackage

// ===== rtl/glyph_alpha_blend_blit.sv =====
// ----------------------------------------------------------------------------
// glyph_alpha_blend_blit
// An item passes the input register, then the result register. Throughput:
// one item per cycle unless result_ready stalls the output; the blend and the
// address multiply sit between the two registers.
// Reset clears both stages, the glyph counters and all registers
// (glyph_width resets to 1).
// ----------------------------------------------------------------------------
module glyph_alpha_blend_blit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  gabb_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output gabb_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gabb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gabb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gabb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  gabb_pkg::cfg_t cfg;

  gabb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [7:0]  column_count;
  logic [7:0]  row_count;
  logic [7:0]  column_count_next;
  logic [7:0]  row_count_next;
  logic [7:0]  col_cur;
  logic [7:0]  row_cur;
  logic [7:0]  gw;

  logic        s1_valid;
  logic [7:0]  s1_coverage;
  logic [23:0] s1_bg;
  logic [7:0]  s1_col;
  logic [7:0]  s1_row;

  logic        adv2;

  assign adv2       = !result_valid || result_ready;
  assign item_ready = !s1_valid || adv2;

  always_comb begin
    col_cur = item.first_of_glyph ? 8'd0 : column_count;
    row_cur = item.first_of_glyph ? 8'd0 : row_count;
    gw      = (cfg.glyph_width == 8'd0) ? 8'd1 : cfg.glyph_width;
    if (({1'b0, col_cur} + 9'd1) >= {1'b0, gw}) begin
      column_count_next = 8'd0;
      row_count_next    = row_cur + 8'd1;
    end else begin
      column_count_next = col_cur + 8'd1;
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
      if (item_valid) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_coverage <= item.coverage;
      s1_bg       <= item.background_pixel;
      s1_col      <= col_cur;
      s1_row      <= row_cur;
    end
  end

  logic signed [16:0] px;
  logic signed [16:0] py;
  logic [12:0]        bw;
  logic [12:0]        bh;
  logic               in_buf;
  logic [26:0]        row_base;
  logic [27:0]        addr_sum;
  logic [23:0]        pixel;
  gabb_pkg::result_t  result_next;

  gabb_blend u_blend (
    .bg    (s1_bg),
    .fg    (cfg.fg_color),
    .alpha (s1_coverage),
    .pixel (pixel)
  );

  always_comb begin
    px = {cfg.origin_x[15], cfg.origin_x} + $signed({9'd0, s1_col});
    py = {cfg.origin_y[15], cfg.origin_y} + $signed({9'd0, s1_row});
    bw = (cfg.buf_width > 13'(gabb_pkg::MAX_BUF_DIM))
         ? 13'(gabb_pkg::MAX_BUF_DIM) : cfg.buf_width;
    bh = (cfg.buf_height > 13'(gabb_pkg::MAX_BUF_DIM))
         ? 13'(gabb_pkg::MAX_BUF_DIM) : cfg.buf_height;
    in_buf = (s1_coverage != 8'd0) && !px[16] && !py[16]
             && (px[15:0] < {3'd0, bw}) && (py[15:0] < {3'd0, bh});
    row_base = py[12:0] * cfg.row_pitch;
    addr_sum = {1'b0, row_base} + {15'd0, px[12:0]};
    result_next.write_enable  = in_buf;
    result_next.word_address  = in_buf ? addr_sum[24:0] : 25'd0;
    result_next.blended_pixel = pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv2) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/gabb_regs.sv =====
// ----------------------------------------------------------------------------
// gabb_regs
// APB register file holding the blitter configuration.
// ----------------------------------------------------------------------------
module gabb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gabb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gabb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gabb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output gabb_pkg::cfg_t                  cfg
);

  logic [gabb_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[gabb_pkg::APB_ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color    <= '0;
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.buf_width   <= '0;
      cfg.buf_height  <= '0;
      cfg.row_pitch   <= '0;
      cfg.glyph_width <= 8'd1;
    end else if (wr) begin
      case (idx)
        gabb_pkg::REG_FG_COLOR:    cfg.fg_color    <= pwdata[23:0];
        gabb_pkg::REG_ORIGIN_X:    cfg.origin_x    <= pwdata[15:0];
        gabb_pkg::REG_ORIGIN_Y:    cfg.origin_y    <= pwdata[15:0];
        gabb_pkg::REG_BUF_WIDTH:   cfg.buf_width   <= pwdata[12:0];
        gabb_pkg::REG_BUF_HEIGHT:  cfg.buf_height  <= pwdata[12:0];
        gabb_pkg::REG_ROW_PITCH:   cfg.row_pitch   <= pwdata[13:0];
        gabb_pkg::REG_GLYPH_WIDTH: cfg.glyph_width <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gabb_pkg::REG_FG_COLOR:    prdata = {8'd0, cfg.fg_color};
      gabb_pkg::REG_ORIGIN_X:    prdata = {16'd0, cfg.origin_x};
      gabb_pkg::REG_ORIGIN_Y:    prdata = {16'd0, cfg.origin_y};
      gabb_pkg::REG_BUF_WIDTH:   prdata = {19'd0, cfg.buf_width};
      gabb_pkg::REG_BUF_HEIGHT:  prdata = {19'd0, cfg.buf_height};
      gabb_pkg::REG_ROW_PITCH:   prdata = {18'd0, cfg.row_pitch};
      gabb_pkg::REG_GLYPH_WIDTH: prdata = {24'd0, cfg.glyph_width};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/gabb_blend.sv =====
// ----------------------------------------------------------------------------
// gabb_blend
// Per-channel RGB888 blend bg + trunc((fg - bg) * alpha / 255).
// ----------------------------------------------------------------------------
module gabb_blend (
  input  logic [23:0] bg,
  input  logic [23:0] fg,
  input  logic [7:0]  alpha,
  output logic [23:0] pixel
);

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  f;
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [16:0] sum;
    logic [7:0]  q;
    pixel = '0;
    for (int c = 0; c < 3; c++) begin
      b    = bg[c*8 +: 8];
      f    = fg[c*8 +: 8];
      diff = (f >= b) ? (f - b) : (b - f);
      prod = diff * alpha;
      // exact divide by 255 for every product up to 255*255
      sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
      q    = sum[15:8];
      pixel[c*8 +: 8] = (f >= b) ? (b + q) : (b - q);
    end
  end

endmodule

// ===== bench/glyph_blend_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_blend_checker
// Watches the pixel, result and register ports of the glyph blitter. Keeps a
// shadow of the registers and the glyph column/row counters, predicts the
// blended pixel, write enable and word address of every pixel transfer, and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_blend_checker
  import gabb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending,
  output int                    pixels_seen,
  output int                    pixels_written
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       blit_cfg;
  logic [7:0] glyph_col;
  logic [7:0] glyph_row;
  result_t    expected_pixels[$];

  function automatic logic [7:0] channel_lerp(logic [7:0] bg, logic [7:0] fg,
                                              logic [7:0] a);
    if (fg >= bg) return bg + 8'((32'(fg) - 32'(bg)) * 32'(a) / 32'd255);
    return bg - 8'((32'(bg) - 32'(fg)) * 32'(a) / 32'd255);
  endfunction

  function automatic logic [23:0] coverage_blend(logic [23:0] bg, logic [23:0] fg,
                                                 logic [7:0] a);
    return {channel_lerp(bg[23:16], fg[23:16], a),
            channel_lerp(bg[15:8], fg[15:8], a),
            channel_lerp(bg[7:0], fg[7:0], a)};
  endfunction

  function automatic result_t blit_pixel(item_t it);
    result_t r;
    int px, py, bw, bh, gw;
    if (it.first_of_glyph) begin
      glyph_col = '0;
      glyph_row = '0;
    end
    bw = (blit_cfg.buf_width > MAX_BUF_DIM) ? MAX_BUF_DIM : int'(blit_cfg.buf_width);
    bh = (blit_cfg.buf_height > MAX_BUF_DIM) ? MAX_BUF_DIM : int'(blit_cfg.buf_height);
    px = int'(blit_cfg.origin_x) + int'(glyph_col);
    py = int'(blit_cfg.origin_y) + int'(glyph_row);
    r.write_enable = (it.coverage != 8'd0) && px >= 0 && py >= 0 && px < bw && py < bh;
    r.word_address = r.write_enable ? 25'(py * int'(blit_cfg.row_pitch) + px) : '0;
    r.blended_pixel = coverage_blend(it.background_pixel, blit_cfg.fg_color,
                                     it.coverage);
    gw = int'(blit_cfg.glyph_width);
    if (gw == 0) gw = 1;
    if (gw > MAX_GLYPH_DIM) gw = MAX_GLYPH_DIM;
    if (int'(glyph_col) + 1 >= gw) begin
      glyph_col = '0;
      glyph_row = glyph_row + 8'd1;
    end else begin
      glyph_col = glyph_col + 8'd1;
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    pixels_seen = 0;
    pixels_written = 0;
  end

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      blit_cfg = '0;
      blit_cfg.glyph_width = 8'd1;
      glyph_col = '0;
      glyph_row = '0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_IDX_W+1:2])
          REG_FG_COLOR:    blit_cfg.fg_color    = pwdata[23:0];
          REG_ORIGIN_X:    blit_cfg.origin_x    = pwdata[15:0];
          REG_ORIGIN_Y:    blit_cfg.origin_y    = pwdata[15:0];
          REG_BUF_WIDTH:   blit_cfg.buf_width   = pwdata[12:0];
          REG_BUF_HEIGHT:  blit_cfg.buf_height  = pwdata[12:0];
          REG_ROW_PITCH:   blit_cfg.row_pitch   = pwdata[13:0];
          REG_GLYPH_WIDTH: blit_cfg.glyph_width = pwdata[7:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        pixels_seen++;
        if (result.write_enable) pixels_written++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result transfer with nothing expected: we=%0b addr=%h px=%h",
                     $time, result.write_enable, result.word_address,
                     result.blended_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (result.write_enable !== want.write_enable ||
              result.word_address !== want.word_address ||
              result.blended_pixel !== want.blended_pixel) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] pixel mismatch: expected we=%0b addr=%h px=%h, ",
                        "got we=%0b addr=%h px=%h"}, $time,
                       want.write_enable, want.word_address, want.blended_pixel,
                       result.write_enable, result.word_address,
                       result.blended_pixel);
          end
        end
      end
      if (item_valid && item_ready) expected_pixels.push_back(blit_pixel(item));
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the glyph alpha blend blitter with directed pixels and then random
// glyph boxes under many register settings, with random idling on both
// transfer channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gabb_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int CALM_ITEMS     = 200;
  localparam int HOLD_CYCLES    = 200;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches, pending, pixels_seen, pixels_written;
  int sent = 0;
  int reg_writes = 0;
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;

  glyph_alpha_blend_blit DUT (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  glyph_blend_checker checker_i (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .pending, .pixels_seen, .pixels_written
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_sink
    int n;
    forever begin
      if (long_hold_req) begin
        @(negedge clk) result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        @(negedge clk) result_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 12);
        @(negedge clk) result_ready <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  task automatic program_blit(logic [23:0] fg, int ox, int oy, int bw, int bh,
                              int pitch, int gw);
    write_reg(REG_FG_COLOR, 32'(fg));
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_BUF_WIDTH, 32'(bw));
    write_reg(REG_BUF_HEIGHT, 32'(bh));
    write_reg(REG_ROW_PITCH, 32'(pitch));
    write_reg(REG_GLYPH_WIDTH, 32'(gw));
  endtask

  task automatic send_pixel(logic [7:0] cov, logic [23:0] bg, logic first);
    @(negedge clk);
    item_valid <= 1'b1;
    item <= '{coverage: cov, background_pixel: bg, first_of_glyph: first};
    do @(posedge clk); while (!item_ready);
    sent++;
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 6);
      @(negedge clk) item_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // drop valid and hold until every predicted pixel has come back
  task automatic quiesce();
    @(negedge clk) item_valid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [7:0] pick_coverage();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 8191;
      2: return MAX_BUF_DIM;
      3: return $urandom_range(0, 8191);
      default: return $urandom_range(16, 64);
    endcase
  endfunction

  task automatic send_glyph(int w, int h);
    logic first;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        first = (r == 0 && c == 0 && $urandom_range(0, 19) != 0) ||
                $urandom_range(0, 99) == 0;
        send_pixel(pick_coverage(), 24'($urandom_range(0, 24'hFFFFFF)), first);
        sender_gap();
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0]  cov_list[8] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255, 8'd255, 8'd64};
    logic [23:0] bg_list[8]  = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'hFEDCBA,
                                 24'h00FF00, 24'hFFFFFF, 24'h000000, 24'h80FF7F};
    int start, phase, w, h, gw, bw, bh, bwc, bhc, ox, oy, pitch, glyphs;
    logic [23:0] fg;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset settings: empty buffer, one-wide glyph
    send_pixel(8'd255, 24'h000000, 1'b1);
    send_pixel(8'd0, 24'hFFFFFF, 1'b0);
    quiesce();

    program_blit(24'hFF0080, 0, 0, 16, 16, 16, 4);
    for (int i = 0; i < 8; i++) send_pixel(cov_list[i], bg_list[i], i == 0);
    quiesce();

    // zero glyph width, saturated buffer, address wrap
    program_blit(24'hFFFFFF, 4095, 4000, 8191, 8191, 16383, 0);
    send_pixel(8'd200, 24'h0F0F0F, 1'b1);
    send_pixel(8'd200, 24'hF0F0F0, 1'b0);
    quiesce();

    // clipping on the left and top, zero pitch
    program_blit(24'h000000, -2, -1, 4096, 4096, 0, 3);
    for (int i = 0; i < 6; i++) send_pixel(8'd255, 24'hA5A5A5, i == 0);
    quiesce();

    // glyph width lowered under the current column
    program_blit(24'h3C7E99, 0, 0, 16, 16, 16, 8);
    for (int i = 0; i < 5; i++) send_pixel(8'd90, 24'h5A5A5A, i == 0);
    quiesce();
    write_reg(REG_GLYPH_WIDTH, 32'd3);
    send_pixel(8'd90, 24'h5A5A5A, 1'b0);
    send_pixel(8'd90, 24'h5A5A5A, 1'b0);
    quiesce();

    // unmapped register, dropped color top byte, origin extremes
    write_reg(REG_UNMAPPED, 32'hDEADBEEF);
    write_reg(REG_FG_COLOR, 32'hAB123456);
    write_reg(REG_ORIGIN_X, 32'h00007FFF);
    write_reg(REG_ORIGIN_Y, 32'hFFFF8000);
    send_pixel(8'd255, 24'h000000, 1'b1);
    quiesce();

    start = sent;
    phase = 0;
    while (sent - start < RANDOM_ITEMS) begin
      quiesce();
      case ($urandom_range(0, 9))
        0: gw = 0;
        1: gw = MAX_GLYPH_DIM;
        2: gw = 1;
        default: gw = $urandom_range(2, 12);
      endcase
      w = (gw == 0) ? 1 : gw;
      h = (gw == MAX_GLYPH_DIM) ? 1 : $urandom_range(1, 6);
      bw = pick_extent();
      bh = pick_extent();
      bwc = (bw > MAX_BUF_DIM) ? MAX_BUF_DIM : bw;
      bhc = (bh > MAX_BUF_DIM) ? MAX_BUF_DIM : bh;
      case ($urandom_range(0, 9))
        0: ox = -32768;
        1: ox = 32767;
        default: ox = int'($urandom_range(0, bwc + 2 * w)) - w;
      endcase
      case ($urandom_range(0, 9))
        0: oy = -32768;
        1: oy = 32767;
        default: oy = int'($urandom_range(0, bhc + 2 * h)) - h;
      endcase
      case ($urandom_range(0, 7))
        0: pitch = 0;
        1: pitch = 16383;
        2: pitch = 8192;
        default: pitch = bwc + $urandom_range(0, 16);
      endcase
      case ($urandom_range(0, 7))
        0: fg = 24'h000000;
        1: fg = 24'hFFFFFF;
        default: fg = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      program_blit(fg, ox, oy, bw, bh, pitch, gw);
      if (phase == 3) long_hold_req = 1'b1;
      if (sent - start >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      glyphs = (w * h > 100) ? 1 : $urandom_range(2, 5);
      repeat (glyphs) send_glyph(w, h);
      phase++;
    end

    quiesce();
    repeat (8) @(posedge clk);
    $display("Covered %0d pixel transfers (%0d with write enable) over %0d register writes,",
             pixels_seen, pixels_written, reg_writes);
    $display("including clipping, address wrap, glyph restarts and a long output stall.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
